[rtl/bankers_safety_check_unit_defines.svh]
// ----------------------------------------------------------------------------
// bankers safety check unit: assertion macros
// Shared assertion forms, clocked on clk_i with the active-low reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef BANKERS_SAFETY_CHECK_UNIT_DEFINES_SVH
`define BANKERS_SAFETY_CHECK_UNIT_DEFINES_SVH

// property checked outside reset
`define BSC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// property that also holds while reset is applied
`define BSC_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/bsc_pkg.sv]
// ----------------------------------------------------------------------------
// bsc_pkg
// Types, sizes and codes shared by the safety check unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  // table dimensions
  localparam int MaxProcs = 16;
  localparam int MaxRes   = 8;

  // fixed field widths
  localparam int ReqTypeW  = 2;
  localparam int ProcIdxW  = 4;
  localparam int ResIdxW   = 3;
  localparam int AmountW   = 16;
  localparam int KindW     = 2;
  localparam int AvailW    = 20;
  localparam int VerdictW  = 2;
  localparam int NumProcsW = 5;
  localparam int NumResW   = 4;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 5;

  // derived internal widths
  localparam int ProcCntW = $clog2(MaxProcs + 1);
  localparam int ResCntW  = $clog2(MaxRes + 1);
  localparam int PSelW    = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
  localparam int RSelW    = (MaxRes > 1) ? $clog2(MaxRes) : 1;
  localparam int TblDepth = MaxProcs * MaxRes;
  localparam int TblAddrW = $clog2(TblDepth);
  localparam int SumW     = AvailW + 1;

  localparam logic [AvailW-1:0] AvailMax = {AvailW{1'b1}};

  // request codes
  typedef enum logic [ReqTypeW-1:0] {
    ReqAlloc = 2'd0,
    ReqMax   = 2'd1,
    ReqAvail = 2'd2,
    ReqRun   = 2'd3
  } req_e;

  // result kinds
  typedef enum logic [KindW-1:0] {
    KindSeq     = 2'd0,
    KindAvail   = 2'd1,
    KindVerdict = 2'd2
  } kind_e;

  // verdict codes
  typedef enum logic [VerdictW-1:0] {
    VerdSafe     = 2'd0,
    VerdDeadlock = 2'd1,
    VerdPartial  = 2'd2
  } verdict_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgNumProcs = 2'd0,
    CfgNumRes   = 2'd1
  } cfg_idx_e;

  // shared port of the two table memories
  typedef struct packed {
    logic                we_alloc;
    logic                we_max;
    logic [TblAddrW-1:0] addr;
    logic [AmountW-1:0]  wdata;
  } tbl_req_t;

endpackage

`default_nettype wire

[rtl/bsc_if.sv]
// ----------------------------------------------------------------------------
// bsc_if
// Valid/ready channels of the safety check unit: request, result, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsc_req_if;
  logic                         valid;
  logic                         ready;
  logic [bsc_pkg::ReqTypeW-1:0] req_type;
  logic [bsc_pkg::ProcIdxW-1:0] proc_index;
  logic [bsc_pkg::ResIdxW-1:0]  res_index;
  logic [bsc_pkg::AmountW-1:0]  amount;

  modport source (output valid, req_type, proc_index, res_index, amount, input ready);
  modport sink   (input valid, req_type, proc_index, res_index, amount, output ready);
endinterface

interface bsc_res_if;
  logic                         valid;
  logic                         ready;
  logic [bsc_pkg::KindW-1:0]    kind;
  logic [bsc_pkg::ProcIdxW-1:0] proc_id;
  logic [bsc_pkg::ResIdxW-1:0]  res_slot;
  logic [bsc_pkg::AvailW-1:0]   avail_out;
  logic [bsc_pkg::VerdictW-1:0] verdict;
  logic                         last;

  modport source (output valid, kind, proc_id, res_slot, avail_out, verdict, last,
                  input ready);
  modport sink   (input valid, kind, proc_id, res_slot, avail_out, verdict, last,
                  output ready);
endinterface

interface bsc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bsc_pkg::CfgIdxW-1:0]  index;
  logic [bsc_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/bankers_safety_check_unit.sv]
// ----------------------------------------------------------------------------
// bankers_safety_check_unit
// Banker's algorithm safety check over loaded allocation and maximum tables.
// ----------------------------------------------------------------------------
// Load requests (allocation, maximum or available entry) produce no result;
// the unit is ready for the next one at once. A run request clears the
// finished marks and walks the tables: each unfinished process is checked
// one resource at a time (one table read per cycle through the single port
// of the allocation and maximum memories, compare in the next cycle, early
// exit on the first short resource), a finished process is skipped, and
// every process found restarts the walk at process zero. A run gives up to
// num_procs + num_res + 1 results. Further requests wait until the verdict
// has been placed in the output register. The available amounts are updated
// in place, so a later run starts from the final amounts.
`default_nettype none

`include "bankers_safety_check_unit_defines.svh"

module bankers_safety_check_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bsc_req_if.sink   req_i,
  bsc_res_if.source res_o,
  bsc_cfg_if.sink   cfg_i
);

  logic [bsc_pkg::NumProcsW-1:0] num_procs_q;
  logic [bsc_pkg::NumResW-1:0]   num_res_q;
  bsc_pkg::tbl_req_t             tbl_req;
  logic [bsc_pkg::AmountW-1:0]   alloc_rdata;
  logic [bsc_pkg::AmountW-1:0]   max_rdata;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_procs_q <= bsc_pkg::NumProcsW'(1);
      num_res_q   <= bsc_pkg::NumResW'(1);
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        bsc_pkg::CfgNumProcs: num_procs_q <= bsc_pkg::NumProcsW'(cfg_i.data);
        bsc_pkg::CfgNumRes:   num_res_q   <= bsc_pkg::NumResW'(cfg_i.data);
        default: begin
        end
      endcase
    end
  end

  // allocation table
  bsc_ram #(
    .Width (bsc_pkg::AmountW),
    .Depth (bsc_pkg::TblDepth)
  ) u_alloc_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_req.we_alloc),
    .addr_i  (tbl_req.addr),
    .wdata_i (tbl_req.wdata),
    .rdata_o (alloc_rdata)
  );

  // maximum table
  bsc_ram #(
    .Width (bsc_pkg::AmountW),
    .Depth (bsc_pkg::TblDepth)
  ) u_max_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_req.we_max),
    .addr_i  (tbl_req.addr),
    .wdata_i (tbl_req.wdata),
    .rdata_o (max_rdata)
  );

  // sequencer
  bsc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .res_o         (res_o),
    .num_procs_i   (num_procs_q),
    .num_res_i     (num_res_q),
    .tbl_o         (tbl_req),
    .alloc_rdata_i (alloc_rdata),
    .max_rdata_i   (max_rdata)
  );

  // checks
  `BSC_ASSERT(a_run_goes_busy, (req_i.valid && req_i.ready && req_i.req_type == bsc_pkg::ReqRun) |=> !req_i.ready, "run request did not make the unit busy")
  `BSC_ASSERT(a_seq_while_busy, (res_o.valid && res_o.kind == bsc_pkg::KindSeq) |-> !req_i.ready, "sequence result pending while idle")
  `BSC_ASSERT(a_tbl_write_idle, (tbl_req.we_alloc || tbl_req.we_max) |-> (req_i.ready && !(tbl_req.we_alloc && tbl_req.we_max)), "table write outside idle or to both tables")
  `BSC_ASSERT_RST(a_reset_no_result, !rst_ni |=> !res_o.valid, "result valid straight after reset")

endmodule

`default_nettype wire

[rtl/bsc_ram.sv]
// ----------------------------------------------------------------------------
// bsc_ram
// Generic single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_ram #(
  parameter int Width = 16,
  parameter int Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/bsc_ctrl.sv]
// ----------------------------------------------------------------------------
// bsc_ctrl
// Request decode, table walk sequencer, available vector and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  bsc_req_if.sink                              req_i,
  bsc_res_if.source                            res_o,
  input  wire logic [bsc_pkg::NumProcsW-1:0]   num_procs_i,
  input  wire logic [bsc_pkg::NumResW-1:0]     num_res_i,
  output bsc_pkg::tbl_req_t                    tbl_o,
  input  wire logic [bsc_pkg::AmountW-1:0]     alloc_rdata_i,
  input  wire logic [bsc_pkg::AmountW-1:0]     max_rdata_i
);

  typedef enum logic [2:0] {
    SIdle,
    SScan,
    SRead,
    SSeq,
    SAvail,
    SVerdict
  } state_e;

  state_e                          state_q, state_d;
  logic [bsc_pkg::ProcCntW-1:0]    p_q, p_d;
  logic [bsc_pkg::ResCntW-1:0]     r_q, r_d;
  logic                            rd_vld_q, rd_vld_d;
  logic [bsc_pkg::RSelW-1:0]       rd_idx_q, rd_idx_d;
  logic [bsc_pkg::ProcCntW-1:0]    done_q, done_d;
  logic [bsc_pkg::ProcCntW-1:0]    np_q, np_d;
  logic [bsc_pkg::ResCntW-1:0]     nr_q, nr_d;
  logic [bsc_pkg::MaxProcs-1:0]    fin_q, fin_d;

  logic [bsc_pkg::AvailW-1:0]      avail_q [bsc_pkg::MaxRes];
  logic [bsc_pkg::AvailW-1:0]      avail_d [bsc_pkg::MaxRes];
  logic [bsc_pkg::AvailW-1:0]      pend_q  [bsc_pkg::MaxRes];
  logic [bsc_pkg::AvailW-1:0]      pend_d  [bsc_pkg::MaxRes];

  logic                            out_vld_q, out_vld_d;
  logic [bsc_pkg::KindW-1:0]       out_kind_q, out_kind_d;
  logic [bsc_pkg::ProcIdxW-1:0]    out_pid_q, out_pid_d;
  logic [bsc_pkg::ResIdxW-1:0]     out_slot_q, out_slot_d;
  logic [bsc_pkg::AvailW-1:0]      out_av_q, out_av_d;
  logic [bsc_pkg::VerdictW-1:0]    out_verd_q, out_verd_d;
  logic                            out_last_q, out_last_d;

  logic                            req_acc;
  logic                            load_ok;
  logic                            slot_free;
  logic [bsc_pkg::PSelW-1:0]       p_sel;
  logic [bsc_pkg::RSelW-1:0]       av_sel;
  logic [bsc_pkg::AvailW-1:0]      av_rd;
  logic [bsc_pkg::SumW-1:0]        sum;
  logic [bsc_pkg::AvailW-1:0]      sum_sat;
  logic                            need_fail;
  logic [bsc_pkg::TblAddrW-1:0]    load_addr;
  logic [bsc_pkg::TblAddrW-1:0]    walk_addr;

  assign req_acc   = req_i.valid && req_i.ready;
  assign slot_free = !out_vld_q || res_o.ready;
  assign load_ok   = (int'(req_i.proc_index) < bsc_pkg::MaxProcs) &&
                     (int'(req_i.res_index) < bsc_pkg::MaxRes);
  assign p_sel     = bsc_pkg::PSelW'(p_q);

  // table addresses: row-major, one row per process
  assign load_addr = bsc_pkg::TblAddrW'(
                       bsc_pkg::TblAddrW'(req_i.proc_index) *
                       bsc_pkg::TblAddrW'(bsc_pkg::MaxRes) +
                       bsc_pkg::TblAddrW'(req_i.res_index));
  assign walk_addr = bsc_pkg::TblAddrW'(
                       bsc_pkg::TblAddrW'(p_q) *
                       bsc_pkg::TblAddrW'(bsc_pkg::MaxRes) +
                       bsc_pkg::TblAddrW'(r_q));

  // single read port of the available vector
  assign av_sel = (state_q == SAvail) ? bsc_pkg::RSelW'(r_q) : rd_idx_q;
  assign av_rd  = avail_q[av_sel];

  // need check and saturated refund
  assign sum       = {1'b0, av_rd} + bsc_pkg::SumW'(alloc_rdata_i);
  assign need_fail = bsc_pkg::SumW'(max_rdata_i) > sum;
  assign sum_sat   = sum[bsc_pkg::AvailW] ? bsc_pkg::AvailMax : sum[bsc_pkg::AvailW-1:0];

  // sequencer next state
  always_comb begin
    state_d    = state_q;
    p_d        = p_q;
    r_d        = r_q;
    rd_vld_d   = rd_vld_q;
    rd_idx_d   = rd_idx_q;
    done_d     = done_q;
    np_d       = np_q;
    nr_d       = nr_q;
    fin_d      = fin_q;
    avail_d    = avail_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q;
    out_kind_d = out_kind_q;
    out_pid_d  = out_pid_q;
    out_slot_d = out_slot_q;
    out_av_d   = out_av_q;
    out_verd_d = out_verd_q;
    out_last_d = out_last_q;

    tbl_o.we_alloc = 1'b0;
    tbl_o.we_max   = 1'b0;
    tbl_o.addr     = (state_q == SIdle) ? load_addr : walk_addr;
    tbl_o.wdata    = req_i.amount;

    // result taken downstream
    if (res_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      SIdle: begin
        if (req_acc) begin
          if (req_i.req_type == bsc_pkg::ReqRun) begin
            // clamp the configured sizes and start the walk
            if (num_procs_i == '0) begin
              np_d = bsc_pkg::ProcCntW'(1);
            end else if (int'(num_procs_i) > bsc_pkg::MaxProcs) begin
              np_d = bsc_pkg::ProcCntW'(bsc_pkg::MaxProcs);
            end else begin
              np_d = bsc_pkg::ProcCntW'(num_procs_i);
            end
            if (num_res_i == '0) begin
              nr_d = bsc_pkg::ResCntW'(1);
            end else if (int'(num_res_i) > bsc_pkg::MaxRes) begin
              nr_d = bsc_pkg::ResCntW'(bsc_pkg::MaxRes);
            end else begin
              nr_d = bsc_pkg::ResCntW'(num_res_i);
            end
            fin_d   = '0;
            done_d  = '0;
            p_d     = '0;
            state_d = SScan;
          end else if (load_ok) begin
            tbl_o.we_alloc = (req_i.req_type == bsc_pkg::ReqAlloc);
            tbl_o.we_max   = (req_i.req_type == bsc_pkg::ReqMax);
            if (req_i.req_type == bsc_pkg::ReqAvail) begin
              avail_d[bsc_pkg::RSelW'(req_i.res_index)] =
                bsc_pkg::AvailW'(req_i.amount);
            end
          end
        end
      end

      SScan: begin
        // pick the next unfinished process, or end the walk
        if (p_q >= np_q) begin
          r_d     = '0;
          state_d = SAvail;
        end else if (fin_q[p_sel]) begin
          p_d = p_q + bsc_pkg::ProcCntW'(1);
        end else begin
          r_d      = '0;
          rd_vld_d = 1'b0;
          state_d  = SRead;
        end
      end

      SRead: begin
        // issue one table read per cycle
        if (r_q < nr_q) begin
          rd_vld_d = 1'b1;
          rd_idx_d = bsc_pkg::RSelW'(r_q);
          r_d      = r_q + bsc_pkg::ResCntW'(1);
        end else begin
          rd_vld_d = 1'b0;
        end
        // compare the entry read last cycle
        if (rd_vld_q) begin
          if (need_fail) begin
            p_d      = p_q + bsc_pkg::ProcCntW'(1);
            rd_vld_d = 1'b0;
            state_d  = SScan;
          end else begin
            pend_d[rd_idx_q] = sum_sat;
            if (bsc_pkg::ResCntW'(rd_idx_q) == nr_q - bsc_pkg::ResCntW'(1)) begin
              rd_vld_d = 1'b0;
              state_d  = SSeq;
            end
          end
        end
      end

      SSeq: begin
        // commit the refund and report the process
        if (slot_free) begin
          out_vld_d    = 1'b1;
          out_kind_d   = bsc_pkg::KindSeq;
          out_pid_d    = bsc_pkg::ProcIdxW'(p_q);
          out_slot_d   = '0;
          out_av_d     = '0;
          out_verd_d   = '0;
          out_last_d   = 1'b0;
          fin_d[p_sel] = 1'b1;
          for (int r = 0; r < bsc_pkg::MaxRes; r++) begin
            if (r < int'(nr_q)) begin
              avail_d[r] = pend_q[r];
            end
          end
          done_d  = done_q + bsc_pkg::ProcCntW'(1);
          p_d     = '0;
          state_d = SScan;
        end
      end

      SAvail: begin
        // final available amounts, one per result
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_kind_d = bsc_pkg::KindAvail;
          out_pid_d  = '0;
          out_slot_d = bsc_pkg::ResIdxW'(r_q);
          out_av_d   = av_rd;
          out_verd_d = '0;
          out_last_d = 1'b0;
          r_d        = r_q + bsc_pkg::ResCntW'(1);
          if (r_q == nr_q - bsc_pkg::ResCntW'(1)) begin
            state_d = SVerdict;
          end
        end
      end

      SVerdict: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_kind_d = bsc_pkg::KindVerdict;
          out_pid_d  = '0;
          out_slot_d = '0;
          out_av_d   = '0;
          out_last_d = 1'b1;
          if (done_q == '0) begin
            out_verd_d = bsc_pkg::VerdDeadlock;
          end else if (done_q == np_q) begin
            out_verd_d = bsc_pkg::VerdSafe;
          end else begin
            out_verd_d = bsc_pkg::VerdPartial;
          end
          state_d = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      p_q        <= '0;
      r_q        <= '0;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
      done_q     <= '0;
      np_q       <= bsc_pkg::ProcCntW'(1);
      nr_q       <= bsc_pkg::ResCntW'(1);
      fin_q      <= '0;
      out_vld_q  <= 1'b0;
      out_kind_q <= '0;
      out_pid_q  <= '0;
      out_slot_q <= '0;
      out_av_q   <= '0;
      out_verd_q <= '0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      p_q        <= p_d;
      r_q        <= r_d;
      rd_vld_q   <= rd_vld_d;
      rd_idx_q   <= rd_idx_d;
      done_q     <= done_d;
      np_q       <= np_d;
      nr_q       <= nr_d;
      fin_q      <= fin_d;
      out_vld_q  <= out_vld_d;
      out_kind_q <= out_kind_d;
      out_pid_q  <= out_pid_d;
      out_slot_q <= out_slot_d;
      out_av_q   <= out_av_d;
      out_verd_q <= out_verd_d;
      out_last_q <= out_last_d;
    end
  end

  // available vector and pending refunds
  always_ff @(posedge clk_i) begin
    avail_q <= avail_d;
    pend_q  <= pend_d;
  end

  assign req_i.ready     = (state_q == SIdle);
  assign res_o.valid     = out_vld_q;
  assign res_o.kind      = out_kind_q;
  assign res_o.proc_id   = out_pid_q;
  assign res_o.res_slot  = out_slot_q;
  assign res_o.avail_out = out_av_q;
  assign res_o.verdict   = out_verd_q;
  assign res_o.last      = out_last_q;

endmodule

`default_nettype wire
